### design/hvlc_pkg.sv
// Shared types, command codes and code tables of the H.261 variable length coder.
package hvlc_pkg;

  // Command codes carried on in_tuser
  localparam logic [2:0] CMD_RAW = 3'd0;
  localparam logic [2:0] CMD_DC  = 3'd1;
  localparam logic [2:0] CMD_AC  = 3'd2;
  localparam logic [2:0] CMD_MBA = 3'd3;
  localparam logic [2:0] CMD_CBP = 3'd4;
  localparam logic [2:0] CMD_MVD = 3'd5;

  localparam int HVLC_QDEPTH = 2;     // code queue depth
  localparam int CODE_W      = 32;    // widest code word of one item
  localparam int LEN_W       = 6;     // holds 1..32
  localparam int ACC_W       = 39;    // 7 pending bits plus one code word
  localparam int REM_W       = 6;     // holds 0..39

  // One code word waiting for the packer, right aligned
  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } hvlc_code_t;

  // Table entries: {code word (6b), length (4b)}
  localparam logic [9:0] MBA_TAB [34] = '{
    10'h000, 10'h011, 10'h033, 10'h023, 10'h034, 10'h024, 10'h035, 10'h025,
    10'h077, 10'h067, 10'h0B8, 10'h0A8, 10'h098, 10'h088, 10'h078, 10'h068,
    10'h17A, 10'h16A, 10'h15A, 10'h14A, 10'h13A, 10'h12A, 10'h23B, 10'h22B,
    10'h21B, 10'h20B, 10'h1FB, 10'h1EB, 10'h1DB, 10'h1CB, 10'h1BB, 10'h1AB,
    10'h19B, 10'h18B
  };

  localparam logic [9:0] CBP_TAB [64] = '{
    10'h000, 10'h0B5, 10'h095, 10'h0D6, 10'h0D4, 10'h177, 10'h137, 10'h1F8,
    10'h0C4, 10'h167, 10'h127, 10'h1E8, 10'h135, 10'h1B8, 10'h178, 10'h138,
    10'h0B4, 10'h157, 10'h117, 10'h1D8, 10'h115, 10'h198, 10'h158, 10'h118,
    10'h0F6, 10'h0F8, 10'h0D8, 10'h039, 10'h0F5, 10'h0B8, 10'h078, 10'h079,
    10'h0A4, 10'h147, 10'h107, 10'h1C8, 10'h0E6, 10'h0E8, 10'h0C8, 10'h029,
    10'h105, 10'h188, 10'h148, 10'h108, 10'h0E5, 10'h0A8, 10'h068, 10'h069,
    10'h125, 10'h1A8, 10'h168, 10'h128, 10'h0D5, 10'h098, 10'h058, 10'h059,
    10'h0C5, 10'h088, 10'h048, 10'h049, 10'h073, 10'h0A5, 10'h085, 10'h0C6
  };

  localparam logic [9:0] MVD_TAB [32] = '{
    10'h011, 10'h023, 10'h024, 10'h025, 10'h067, 10'h0A8, 10'h088, 10'h068,
    10'h16A, 10'h14A, 10'h12A, 10'h22B, 10'h20B, 10'h1EB, 10'h1CB, 10'h1AB,
    10'h19B, 10'h1BB, 10'h1DB, 10'h1FB, 10'h21B, 10'h23B, 10'h13A, 10'h15A,
    10'h17A, 10'h078, 10'h098, 10'h0B8, 10'h077, 10'h035, 10'h034, 10'h033
  };

  // AC run/level table: {code word (8b), length (4b)}, zero length = no entry
  function automatic logic [11:0] ac_lookup(input logic [4:0] run, input logic [3:0] mag);
    logic [11:0] r;
    r = 12'd0;
    case ({run, mag})
      {5'd0, 4'd1}:  r = {8'd6, 4'd3};
      {5'd0, 4'd2}:  r = {8'd8, 4'd5};
      {5'd0, 4'd3}:  r = {8'd10, 4'd6};
      {5'd0, 4'd4}:  r = {8'd12, 4'd8};
      {5'd0, 4'd5}:  r = {8'd76, 4'd9};
      {5'd0, 4'd6}:  r = {8'd66, 4'd9};
      {5'd0, 4'd7}:  r = {8'd20, 4'd11};
      {5'd0, 4'd8}:  r = {8'd58, 4'd13};
      {5'd0, 4'd9}:  r = {8'd48, 4'd13};
      {5'd0, 4'd10}: r = {8'd38, 4'd13};
      {5'd0, 4'd11}: r = {8'd32, 4'd13};
      {5'd0, 4'd12}: r = {8'd52, 4'd14};
      {5'd0, 4'd13}: r = {8'd50, 4'd14};
      {5'd0, 4'd14}: r = {8'd48, 4'd14};
      {5'd0, 4'd15}: r = {8'd46, 4'd14};
      {5'd1, 4'd1}:  r = {8'd6, 4'd4};
      {5'd1, 4'd2}:  r = {8'd12, 4'd7};
      {5'd1, 4'd3}:  r = {8'd74, 4'd9};
      {5'd1, 4'd4}:  r = {8'd24, 4'd11};
      {5'd1, 4'd5}:  r = {8'd54, 4'd13};
      {5'd1, 4'd6}:  r = {8'd44, 4'd14};
      {5'd1, 4'd7}:  r = {8'd42, 4'd14};
      {5'd2, 4'd1}:  r = {8'd10, 4'd5};
      {5'd2, 4'd2}:  r = {8'd8, 4'd8};
      {5'd2, 4'd3}:  r = {8'd22, 4'd11};
      {5'd2, 4'd4}:  r = {8'd40, 4'd13};
      {5'd2, 4'd5}:  r = {8'd40, 4'd14};
      {5'd3, 4'd1}:  r = {8'd14, 4'd6};
      {5'd3, 4'd2}:  r = {8'd72, 4'd9};
      {5'd3, 4'd3}:  r = {8'd56, 4'd13};
      {5'd3, 4'd4}:  r = {8'd38, 4'd14};
      {5'd4, 4'd1}:  r = {8'd12, 4'd6};
      {5'd4, 4'd2}:  r = {8'd30, 4'd11};
      {5'd4, 4'd3}:  r = {8'd36, 4'd13};
      {5'd5, 4'd1}:  r = {8'd14, 4'd7};
      {5'd5, 4'd2}:  r = {8'd18, 4'd11};
      {5'd5, 4'd3}:  r = {8'd36, 4'd14};
      {5'd6, 4'd1}:  r = {8'd10, 4'd7};
      {5'd6, 4'd2}:  r = {8'd60, 4'd13};
      {5'd7, 4'd1}:  r = {8'd8, 4'd7};
      {5'd7, 4'd2}:  r = {8'd42, 4'd13};
      {5'd8, 4'd1}:  r = {8'd14, 4'd8};
      {5'd8, 4'd2}:  r = {8'd34, 4'd13};
      {5'd9, 4'd1}:  r = {8'd10, 4'd8};
      {5'd9, 4'd2}:  r = {8'd34, 4'd14};
      {5'd10, 4'd1}: r = {8'd78, 4'd9};
      {5'd10, 4'd2}: r = {8'd32, 4'd14};
      {5'd11, 4'd1}: r = {8'd70, 4'd9};
      {5'd12, 4'd1}: r = {8'd68, 4'd9};
      {5'd13, 4'd1}: r = {8'd64, 4'd9};
      {5'd14, 4'd1}: r = {8'd28, 4'd11};
      {5'd15, 4'd1}: r = {8'd26, 4'd11};
      {5'd16, 4'd1}: r = {8'd16, 4'd11};
      {5'd17, 4'd1}: r = {8'd62, 4'd13};
      {5'd18, 4'd1}: r = {8'd52, 4'd13};
      {5'd19, 4'd1}: r = {8'd50, 4'd13};
      {5'd20, 4'd1}: r = {8'd46, 4'd13};
      {5'd21, 4'd1}: r = {8'd44, 4'd13};
      {5'd22, 4'd1}: r = {8'd62, 4'd14};
      {5'd23, 4'd1}: r = {8'd60, 4'd14};
      {5'd24, 4'd1}: r = {8'd58, 4'd14};
      {5'd25, 4'd1}: r = {8'd56, 4'd14};
      {5'd26, 4'd1}: r = {8'd54, 4'd14};
      default:       r = 12'd0;
    endcase
    return r;
  endfunction

endpackage

### design/hvlc_front.sv
// Front end: decodes one command, checks its range and looks up its code word.
module hvlc_front (
  input  logic [2:0]          cmd,
  input  logic [87:0]         fields,   // packed item fields, see top level
  input  logic                last_coeff,
  output logic                code_ok,
  output hvlc_pkg::hvlc_code_t code
);
  import hvlc_pkg::*;

  logic [31:0]       raw_bits;
  logic [5:0]        raw_length;
  logic [7:0]        sym;
  logic [5:0]        run;
  logic signed [7:0] lvl;
  logic              first;
  logic [4:0]        vx, vy, px, py;
  logic [6:0]        mag;
  logic              sign;
  logic [11:0]       ac_e;
  logic [9:0]        ex, ey, tab_e;
  logic [4:0]        dx, dy;
  logic [31:0]       cbits;
  logic [5:0]        clen;

  assign raw_bits   = fields[31:0];
  assign raw_length = fields[37:32];
  assign sym        = fields[45:38];
  assign run        = fields[51:46];
  assign lvl        = fields[59:52];
  assign first      = fields[60];
  assign vx         = fields[65:61];
  assign vy         = fields[70:66];
  assign px         = fields[75:71];
  assign py         = fields[80:76];

  // magnitude and sign of the AC level
  assign sign = lvl[7];
  assign mag  = sign ? 7'(-lvl) : lvl[6:0];
  assign ac_e = (run < 6'd27 && mag < 7'd16) ? ac_lookup(run[4:0], mag[3:0]) : 12'd0;

  // wrapped vector differences
  assign dx = vx - px;
  assign dy = vy - py;
  assign ex = MVD_TAB[dx];
  assign ey = MVD_TAB[dy];

  // command decode and code word build
  always_comb begin
    code_ok = 1'b0;
    cbits   = 32'd0;
    clen    = 6'd0;
    tab_e   = 10'd0;
    unique case (cmd)
      CMD_RAW: begin
        code_ok = raw_length != 6'd0 && raw_length <= 6'd32;
        cbits   = raw_bits & (32'hFFFF_FFFF >> (6'd32 - raw_length));
        clen    = raw_length;
      end
      CMD_DC: begin
        code_ok = sym != 8'd0 && sym != 8'd255;
        cbits   = {24'd0, (sym == 8'd128) ? 8'd255 : sym};
        clen    = 6'd8;
      end
      CMD_AC: begin
        code_ok = lvl != 8'sd0 && lvl != -8'sd128;
        if (first && run == 6'd0 && mag == 7'd1) begin
          cbits = {30'd0, 1'b1, sign};
          clen  = 6'd2;
        end else if (ac_e[3:0] != 4'd0) begin
          cbits = {24'd0, ac_e[11:4] | {7'd0, sign}};
          clen  = {2'd0, ac_e[3:0]};
        end else begin
          // escape: 000001, run, level
          cbits = {12'd0, 6'b000001, run, lvl};
          clen  = 6'd20;
        end
        // end of block
        if (last_coeff) begin
          cbits = {cbits[29:0], 2'b10};
          clen  = clen + 6'd2;
        end
      end
      CMD_MBA: begin
        code_ok = sym != 8'd0 && sym <= 8'd33;
        tab_e   = code_ok ? MBA_TAB[sym[5:0]] : 10'd0;
        cbits   = {26'd0, tab_e[9:4]};
        clen    = {2'd0, tab_e[3:0]};
      end
      CMD_CBP: begin
        code_ok = sym != 8'd0 && sym <= 8'd63;
        tab_e   = CBP_TAB[sym[5:0]];
        cbits   = {26'd0, tab_e[9:4]};
        clen    = {2'd0, tab_e[3:0]};
      end
      CMD_MVD: begin
        code_ok = vx != 5'b10000 && vy != 5'b10000 && px != 5'b10000 && py != 5'b10000;
        cbits   = ({26'd0, ex[9:4]} << ey[3:0]) | {26'd0, ey[9:4]};
        clen    = {2'd0, ex[3:0]} + {2'd0, ey[3:0]};
      end
      default: begin
        code_ok = 1'b0;
      end
    endcase
  end

  assign code.bits = cbits;
  assign code.len  = clen;

endmodule

### design/hvlc_queue.sv
// Short code queue between the front end and the packer.
module hvlc_queue #(
  parameter int DEPTH = hvlc_pkg::HVLC_QDEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hvlc_pkg::hvlc_code_t wr_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output hvlc_pkg::hvlc_code_t rd_entry
);
  import hvlc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hvlc_code_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign valid    = cnt_r != '0;
  assign rd_entry = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

### design/hvlc_back.sv
// Back end: merges code words into the pending bits and emits whole bytes.
module hvlc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  hvlc_pkg::hvlc_code_t q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import hvlc_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;
  logic [ACC_W-1:0] shifted, keep_mask;

  assign out_free  = !out_valid_r || out_ready;
  assign shifted   = acc_r >> (rem_r - REM_W'(8));
  assign keep_mask = (ACC_W'(1) << rem_r) - ACC_W'(1);

  // emit a byte per cycle while the output is free; merge if none is left
  always_comb begin
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    if (rem_r >= REM_W'(8)) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = shifted[7:0];
        out_last_nxt  = rem_r < REM_W'(16);
        rem_nxt       = rem_r - REM_W'(8);
      end
    end else if (q_valid) begin
      q_pop   = 1'b1;
      acc_nxt = ((acc_r & keep_mask) << q_entry.len) | ACC_W'(q_entry.bits);
      rem_nxt = rem_r + REM_W'(q_entry.len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // pending bits never exceed seven plus one code word
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= REM_W'(ACC_W))
    else $error("pending bit count out of range");

  // a code word is merged only once all whole bytes have left
  a_pop_drained: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> rem_r < REM_W'(8))
    else $error("merge while bytes pending");

  // merging adds exactly the code length
  a_merge_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> rem_r == $past(rem_r + REM_W'(q_entry.len)))
    else $error("merge length mismatch");

  // a ready byte is presented next cycle when the output is free
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r >= REM_W'(8) && out_free) |=> out_valid_r)
    else $error("byte not emitted");

endmodule

### design/h261_vlc_bitstream_writer.sv
// Top level of the H.261 variable length coder and bitstream packer.
// Each input item is one coding command; its code word is looked up in the
// same cycle it is accepted and queued, and the packer appends it to the
// pending bits and sends each completed byte, earliest bit in the MSB, with
// tlast on the last byte the item produced. Dropped (out of range) items and
// items that complete no byte give no output. The packer merges a code word
// only once the completed bytes of the one before have left (at most 4 bytes
// per item) and stalls with the output; the front end keeps accepting while
// the code queue has room. Partial bits are kept, never flushed or padded.
module h261_vlc_bitstream_writer #(
  parameter int QUEUE_DEPTH = hvlc_pkg::HVLC_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // raw_bits[31:0], raw_length[37:32], symbol_value[45:38], run_length[51:46],
  // coeff_level[59:52], first_coeff[60], vec_x[65:61], vec_y[70:66],
  // pred_x[75:71], pred_y[80:76], zero fill [87:81]
  input  logic [87:0] in_tdata,
  input  logic [2:0]  in_tuser,   // command[2:0]
  input  logic        in_tlast,   // last_coeff
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast   // last_byte
);
  import hvlc_pkg::*;

  logic       code_ok, q_full, q_valid, q_pop, push;
  hvlc_code_t code, q_entry;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready && code_ok;

  hvlc_front u_front (
    .cmd        (in_tuser),
    .fields     (in_tdata),
    .last_coeff (in_tlast),
    .code_ok    (code_ok),
    .code       (code)
  );

  hvlc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (code),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .rd_entry (q_entry)
  );

  hvlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

### tb/testbench.sv
// Testbench for the H.261 variable length coder and bitstream packer.
`timescale 1ns / 100ps

module testbench;
  import hvlc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  h261_vlc_bitstream_writer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // One coding command
  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] rbits;
    logic [5:0]  rlen;
    logic [7:0]  sym;
    logic [5:0]  run;
    logic [7:0]  lvl;
    logic        first;
    logic        last;
    logic [4:0]  vx, vy, px, py;
  } vlc_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  out_byte_t byte_q[$];
  logic [7:0] pend_bits;
  int         pend_cnt;
  out_byte_t  step_bytes[$];
  int         errors;
  longint     cycles;
  bit         idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run/level code, {code, length}; zero length means escape
  function automatic logic [11:0] ac_code(int run, int mag);
    int cw, nb;
    cw = 0; nb = 0;
    case (run)
      0: case (mag)
        1: begin cw = 6; nb = 3; end   2: begin cw = 8; nb = 5; end
        3: begin cw = 10; nb = 6; end  4: begin cw = 12; nb = 8; end
        5: begin cw = 76; nb = 9; end  6: begin cw = 66; nb = 9; end
        7: begin cw = 20; nb = 11; end 8: begin cw = 58; nb = 13; end
        9: begin cw = 48; nb = 13; end 10: begin cw = 38; nb = 13; end
        11: begin cw = 32; nb = 13; end 12: begin cw = 52; nb = 14; end
        13: begin cw = 50; nb = 14; end 14: begin cw = 48; nb = 14; end
        15: begin cw = 46; nb = 14; end
        default: ;
      endcase
      1: case (mag)
        1: begin cw = 6; nb = 4; end   2: begin cw = 12; nb = 7; end
        3: begin cw = 74; nb = 9; end  4: begin cw = 24; nb = 11; end
        5: begin cw = 54; nb = 13; end 6: begin cw = 44; nb = 14; end
        7: begin cw = 42; nb = 14; end
        default: ;
      endcase
      2: case (mag)
        1: begin cw = 10; nb = 5; end  2: begin cw = 8; nb = 8; end
        3: begin cw = 22; nb = 11; end 4: begin cw = 40; nb = 13; end
        5: begin cw = 40; nb = 14; end
        default: ;
      endcase
      3: case (mag)
        1: begin cw = 14; nb = 6; end  2: begin cw = 72; nb = 9; end
        3: begin cw = 56; nb = 13; end 4: begin cw = 38; nb = 14; end
        default: ;
      endcase
      4: case (mag)
        1: begin cw = 12; nb = 6; end 2: begin cw = 30; nb = 11; end
        3: begin cw = 36; nb = 13; end
        default: ;
      endcase
      5: case (mag)
        1: begin cw = 14; nb = 7; end 2: begin cw = 18; nb = 11; end
        3: begin cw = 36; nb = 14; end
        default: ;
      endcase
      6: if (mag == 1) begin cw = 10; nb = 7; end
         else if (mag == 2) begin cw = 60; nb = 13; end
      7: if (mag == 1) begin cw = 8; nb = 7; end
         else if (mag == 2) begin cw = 42; nb = 13; end
      8: if (mag == 1) begin cw = 14; nb = 8; end
         else if (mag == 2) begin cw = 34; nb = 13; end
      9: if (mag == 1) begin cw = 10; nb = 8; end
         else if (mag == 2) begin cw = 34; nb = 14; end
      10: if (mag == 1) begin cw = 78; nb = 9; end
          else if (mag == 2) begin cw = 32; nb = 14; end
      default: if (mag == 1) begin
        case (run)
          11: begin cw = 70; nb = 9; end  12: begin cw = 68; nb = 9; end
          13: begin cw = 64; nb = 9; end  14: begin cw = 28; nb = 11; end
          15: begin cw = 26; nb = 11; end 16: begin cw = 16; nb = 11; end
          17: begin cw = 62; nb = 13; end 18: begin cw = 52; nb = 13; end
          19: begin cw = 50; nb = 13; end 20: begin cw = 46; nb = 13; end
          21: begin cw = 44; nb = 13; end 22: begin cw = 62; nb = 14; end
          23: begin cw = 60; nb = 14; end 24: begin cw = 58; nb = 14; end
          25: begin cw = 56; nb = 14; end 26: begin cw = 54; nb = 14; end
          default: ;
        endcase
      end
    endcase
    return {cw[7:0], nb[3:0]};
  endfunction

  // Table entries below are {code[5:0], length[3:0]}
  localparam logic [9:0] MBA_CODES [34] = '{
    10'h000, 10'h011, 10'h033, 10'h023, 10'h034, 10'h024, 10'h035, 10'h025,
    10'h077, 10'h067, 10'h0B8, 10'h0A8, 10'h098, 10'h088, 10'h078, 10'h068,
    10'h17A, 10'h16A, 10'h15A, 10'h14A, 10'h13A, 10'h12A, 10'h23B, 10'h22B,
    10'h21B, 10'h20B, 10'h1FB, 10'h1EB, 10'h1DB, 10'h1CB, 10'h1BB, 10'h1AB,
    10'h19B, 10'h18B};
  localparam logic [9:0] CBP_CODES [64] = '{
    10'h000, 10'h0B5, 10'h095, 10'h0D6, 10'h0D4, 10'h177, 10'h137, 10'h1F8,
    10'h0C4, 10'h167, 10'h127, 10'h1E8, 10'h135, 10'h1B8, 10'h178, 10'h138,
    10'h0B4, 10'h157, 10'h117, 10'h1D8, 10'h115, 10'h198, 10'h158, 10'h118,
    10'h0F6, 10'h0F8, 10'h0D8, 10'h039, 10'h0F5, 10'h0B8, 10'h078, 10'h079,
    10'h0A4, 10'h147, 10'h107, 10'h1C8, 10'h0E6, 10'h0E8, 10'h0C8, 10'h029,
    10'h105, 10'h188, 10'h148, 10'h108, 10'h0E5, 10'h0A8, 10'h068, 10'h069,
    10'h125, 10'h1A8, 10'h168, 10'h128, 10'h0D5, 10'h098, 10'h058, 10'h059,
    10'h0C5, 10'h088, 10'h048, 10'h049, 10'h073, 10'h0A5, 10'h085, 10'h0C6};
  localparam logic [9:0] MVD_CODES [32] = '{
    10'h011, 10'h023, 10'h024, 10'h025, 10'h067, 10'h0A8, 10'h088, 10'h068,
    10'h16A, 10'h14A, 10'h12A, 10'h22B, 10'h20B, 10'h1EB, 10'h1CB, 10'h1AB,
    10'h19B, 10'h1BB, 10'h1DB, 10'h1FB, 10'h21B, 10'h23B, 10'h13A, 10'h15A,
    10'h17A, 10'h078, 10'h098, 10'h0B8, 10'h077, 10'h035, 10'h034, 10'h033};

  // Append code bits MSB first, collecting completed bytes
  function automatic void append_bits(logic [31:0] pattern, int len);
    for (int i = len - 1; i >= 0; i--) begin
      pend_bits = {pend_bits[6:0], pattern[i]};
      pend_cnt++;
      if (pend_cnt == 8) begin
        step_bytes.push_back('{pend_bits, 1'b0});
        pend_bits = '0;
        pend_cnt = 0;
      end
    end
  endfunction

  // Predict the bytes of one accepted command
  function automatic void predict_bytes(vlc_cmd_t c);
    int lvl, mag, dx, dy;
    logic [11:0] ac;
    step_bytes.delete();
    case (c.cmd)
      CMD_RAW: if (c.rlen >= 1 && c.rlen <= 32) append_bits(c.rbits, int'(c.rlen));
      CMD_DC: if (c.sym != 0 && c.sym != 255)
        append_bits(c.sym == 128 ? 32'd255 : {24'd0, c.sym}, 8);
      CMD_AC: begin
        lvl = int'($signed(c.lvl));
        if (lvl != 0 && lvl != -128) begin
          mag = lvl < 0 ? -lvl : lvl;
          ac = ac_code(int'(c.run), mag);
          if (c.first && c.run == 0 && mag == 1)
            append_bits({30'd0, 1'b1, lvl < 0}, 2);
          else if (ac[3:0] != 0)
            append_bits({24'd0, ac[11:4]} | {31'd0, lvl < 0}, int'(ac[3:0]));
          else begin
            append_bits(32'd1, 6);
            append_bits({26'd0, c.run}, 6);
            append_bits({24'd0, c.lvl}, 8);
          end
          if (c.last) append_bits(32'd2, 2);
        end
      end
      CMD_MBA: if (c.sym >= 1 && c.sym <= 33)
        append_bits({26'd0, MBA_CODES[c.sym][9:4]}, int'(MBA_CODES[c.sym][3:0]));
      CMD_CBP: if (c.sym >= 1 && c.sym <= 63)
        append_bits({26'd0, CBP_CODES[c.sym][9:4]}, int'(CBP_CODES[c.sym][3:0]));
      CMD_MVD: if (c.vx != 5'h10 && c.vy != 5'h10 && c.px != 5'h10 && c.py != 5'h10) begin
        dx = ($signed(c.vx) - $signed(c.px)) & 31;
        dy = ($signed(c.vy) - $signed(c.py)) & 31;
        append_bits({26'd0, MVD_CODES[dx][9:4]}, int'(MVD_CODES[dx][3:0]));
        append_bits({26'd0, MVD_CODES[dy][9:4]}, int'(MVD_CODES[dy][3:0]));
      end
      default: ;
    endcase
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
    foreach (step_bytes[i]) byte_q.push_back(step_bytes[i]);
  endfunction

  // Send one command and wait for acceptance; valid stays up for the next one
  task automatic send_cmd(vlc_cmd_t c);
    while (idle_on && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.cmd;
    in_tlast  <= c.last;
    in_tdata  <= {7'd0, c.py, c.px, c.vy, c.vx, c.first, c.lvl, c.run, c.sym,
                  c.rlen, c.rbits};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_bytes(c);
  endtask

  function automatic vlc_cmd_t rand_cmd();
    vlc_cmd_t c;
    c.cmd = 3'($urandom_range(5));
    c.rbits = $urandom();
    c.rlen = 6'($urandom_range(1, 32));
    c.run = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(12));
    c.lvl = 8'(($urandom_range(1) != 0) ? int'($urandom_range(1, 127))
                                        : -int'($urandom_range(1, 127)));
    if ($urandom_range(2) != 0)
      c.lvl = 8'(($urandom_range(1) != 0) ? int'(1 + $urandom_range(4))
                                          : -int'(1 + $urandom_range(4)));
    c.first = 1'($urandom_range(1));
    c.last = 1'($urandom_range(1));
    c.vx = 5'(int'($urandom_range(30)) - 15);
    c.vy = 5'(int'($urandom_range(30)) - 15);
    c.px = 5'(int'($urandom_range(30)) - 15);
    c.py = 5'(int'($urandom_range(30)) - 15);
    case (c.cmd)
      CMD_DC:  c.sym = 8'($urandom_range(1, 254));
      CMD_MBA: c.sym = 8'($urandom_range(1, 33));
      CMD_CBP: c.sym = 8'($urandom_range(1, 63));
      default: c.sym = 8'($urandom());
    endcase
    // a few out of range commands as noise
    if ($urandom_range(19) == 0) begin
      c.sym = ($urandom_range(1) != 0) ? 8'd0 : 8'd255;
      c.rlen = ($urandom_range(1) != 0) ? 6'd0 : 6'($urandom_range(33, 63));
      c.lvl = ($urandom_range(1) != 0) ? 8'h00 : 8'h80;
      c.vx = 5'h10;
      if ($urandom_range(3) == 0) c.cmd = 3'($urandom_range(6, 7));
    end
    return c;
  endfunction

  function automatic vlc_cmd_t blank_cmd(logic [2:0] op);
    vlc_cmd_t c;
    c = '{op, 32'd0, 6'd8, 8'd1, 6'd0, 8'd1, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0, 5'd0};
    return c;
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Field extremes, each operation, a dropped case of each and unknown commands
  task automatic test_directed();
    vlc_cmd_t c;
    c = blank_cmd(CMD_RAW); c.rbits = 32'hFFFF_FFFF; c.rlen = 6'd32; send_cmd(c);
    c.rbits = 32'hA5A5_A5A5; c.rlen = 6'd1; send_cmd(c);
    c.rbits = 32'hFFFF_FF00; c.rlen = 6'd7; send_cmd(c);
    c.rlen = 6'd0; send_cmd(c);
    c.rlen = 6'd63; send_cmd(c);
    c = blank_cmd(CMD_DC); c.sym = 8'd128; send_cmd(c);
    c.sym = 8'd254; send_cmd(c);
    c.sym = 8'd255; send_cmd(c);
    c.sym = 8'd0; send_cmd(c);
    c = blank_cmd(CMD_AC); c.first = 1'b1; c.lvl = 8'hFF; send_cmd(c);
    c.first = 1'b0; c.lvl = 8'd127; c.run = 6'd63; c.last = 1'b1; send_cmd(c);
    c.lvl = 8'h81; c.run = 6'd26; send_cmd(c);
    c.lvl = 8'h80; send_cmd(c);
    c.lvl = 8'd0; send_cmd(c);
    c.lvl = 8'd15; c.run = 6'd0; send_cmd(c);
    c = blank_cmd(CMD_MBA); c.sym = 8'd33; send_cmd(c);
    c.sym = 8'd34; send_cmd(c);
    c = blank_cmd(CMD_CBP); c.sym = 8'd63; send_cmd(c);
    c.sym = 8'd64; send_cmd(c);
    c = blank_cmd(CMD_MVD); c.vx = 5'd15; c.px = 5'h11; c.vy = 5'h11; c.py = 5'd15;
    send_cmd(c);
    c.py = 5'h10; send_cmd(c);
    c = blank_cmd(3'd6); send_cmd(c);
    c = blank_cmd(3'd7); send_cmd(c);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_cmd(rand_cmd());
  endtask

  // Blocks of four AC commands, EOB on the last; random noise may drop some
  task automatic test_blocks(int n);
    vlc_cmd_t c;
    for (int b = 0; b < n; b++) begin
      for (int k = 0; k < 4; k++) begin
        c = rand_cmd();
        c.cmd = CMD_AC;
        c.first = (k == 0);
        c.last = (k == 3);
        send_cmd(c);
      end
    end
  endtask

  // Result checker with random stall on the output side
  always @(posedge clk) begin
    out_byte_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (byte_q.size() == 0) begin
        $display("%0t unexpected byte: expected none, actual %02h/%0b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        e = byte_q.pop_front();
        if (out_tdata !== e.data || out_tlast !== e.last) begin
          $display("%0t mismatch: expected %02h/%0b, actual %02h/%0b",
                   $time, e.data, e.last, out_tdata, out_tlast);
          errors++;
        end
      end
    end
    out_tready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    errors = 0; cycles = 0; idle_on = 1'b1;
    pend_bits = '0; pend_cnt = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(150);
    idle_on = 1'b0;
    test_random(80);
    idle_on = 1'b1;
    test_blocks(40);
    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
design/hvlc_pkg.sv
design/hvlc_front.sv
design/hvlc_queue.sv
design/hvlc_back.sv
design/h261_vlc_bitstream_writer.sv
tb/testbench.sv
